// ===== hw/rtl/tse_pkg.sv =====
package tse_pkg;

    // Fixed field widths.
    localparam int CELL_W  = 10;
    localparam int FRAC_W  = 17;
    localparam int RATE_W  = 22;
    localparam int LEVEL_W = 8;
    localparam int QUOT_W  = 25;
    localparam int CNT_W   = 5;

    // At most this many result words are reported for one request word.
    localparam logic [CNT_W-1:0] MAX_RESULTS = 5'd16;

    // Wave lengths of the tone channels and of the noise channel (channel 3).
    localparam logic [31:0] TONE_LEN       = 32'd64;
    localparam logic [31:0] NOISE_WAVE_LEN = 32'd256;

    // x / 100 for any 32-bit x is (x * DIV100_MAGIC) >> DIV100_SHIFT.
    localparam logic [31:0] DIV100_MAGIC = 32'd1374389535;
    localparam int          DIV100_SHIFT = 37;

    localparam logic [RATE_W-1:0]  RATE_MAX    = 22'h3FFFFF;
    localparam logic [FRAC_W-1:0]  MIN_PERIOD  = 17'd256;
    localparam logic [LEVEL_W-1:0] DECAY_FLOOR = 8'd3;
    localparam logic [3:0]         SEMI_MAX    = 4'd11;
    localparam logic [3:0]         OCT_MAX     = 4'd9;
    localparam logic [3:0]         OCT_REF     = 4'd4;

    // Register reset values.
    localparam logic [15:0] ROW_PERIOD_RST = 16'd15360;
    localparam logic [7:0]  MUSIC_RST      = 8'd255;
    localparam logic [31:0] GAINS_RST      = 32'd303828760;
    localparam logic [31:0] DECAYS_RST     = 32'd3371888884;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROW_PERIOD = 2'd0;
    localparam logic [1:0] CFG_MUSIC      = 2'd1;
    localparam logic [1:0] CFG_GAINS      = 2'd2;
    localparam logic [1:0] CFG_DECAYS     = 2'd3;

    // Score entry kinds; anything else holds.
    localparam logic [1:0] KIND_OFF  = 2'd1;
    localparam logic [1:0] KIND_NOTE = 2'd2;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_PLAY  = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_WRITE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ACT_UPDATE  = 2'd0,
        ACT_SILENCE = 2'd1,
        ACT_START   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_DECAY,
        EMIT_SILENCE,
        EMIT_NOTE
    } emit_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_DECAY,
        ST_ADVANCE,
        ST_ROW_CHECK,
        ST_ROW_READ,
        ST_CELL,
        ST_NOTE_DIV,
        ST_NOTE_EMIT,
        ST_STOP,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic  load;
        logic  clear_step;
        logic  write_cell;
        logic  play_start;
        logic  stop_playing;
        logic  ch_first;
        logic  ch_next;
        logic  frac_add;
        logic  row_take;
        logic  row_advance;
        logic  row_read;
        logic  note_mul;
        logic  note_div;
        emit_t emit;
        logic  flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       clear_last;
        req_t       req_type;
        logic       playing;
        logic       level_zero;
        logic       ch_last;
        logic       row_due;
        logic [1:0] cell_kind;
        logic       emit_ok;
    } dp_status_t;

    typedef struct packed {
        logic [1:0]         channel;
        action_t            action;
        logic [RATE_W-1:0]  rate;
        logic [LEVEL_W-1:0] level;
    } res_t;

    // Note frequency in centihertz for octave 4.
    function automatic logic [15:0] semitone_freq(input logic [3:0] semi);
        logic [15:0] f;
        case (semi)
            4'd0:    f = 16'd26163;
            4'd1:    f = 16'd27718;
            4'd2:    f = 16'd29366;
            4'd3:    f = 16'd31113;
            4'd4:    f = 16'd32963;
            4'd5:    f = 16'd34923;
            4'd6:    f = 16'd36999;
            4'd7:    f = 16'd39200;
            4'd8:    f = 16'd41530;
            4'd9:    f = 16'd44000;
            4'd10:   f = 16'd46616;
            default: f = 16'd49388;
        endcase
        return f;
    endfunction

endpackage

// ===== hw/rtl/tse_if.sv =====
interface tse_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [1:0] frames;
    logic [5:0] cell_row;
    logic [1:0] cell_channel;
    logic [1:0] cell_kind;
    logic [3:0] cell_semitone;
    logic [3:0] cell_octave;

    modport source (
        output valid, req_type, frames, cell_row, cell_channel, cell_kind,
               cell_semitone, cell_octave,
        input  ready
    );
    modport sink (
        input  valid, req_type, frames, cell_row, cell_channel, cell_kind,
               cell_semitone, cell_octave,
        output ready
    );
endinterface

interface tse_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [1:0]  action;
    logic [21:0] sample_rate;
    logic [7:0]  level;
    logic        last;

    modport source (
        output valid, channel, action, sample_rate, level, last,
        input  ready
    );
    modport sink (
        input  valid, channel, action, sample_rate, level, last,
        output ready
    );
endinterface

interface tse_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== hw/rtl/tracker_sequencer_envelope.sv =====
// Four-channel tracker sequencer with decaying volume envelopes.
// Request words arrive on req: a tick (with frames elapsed), play from the
// start, stop, or a score write that stores one pre-decoded entry. Each word
// may produce up to sixteen channel command words on res; the final command
// of a request carries last. Requests that produce nothing (play, score
// write, a tick with no sounding channel while stopped) send no word at all.
// Configuration words on cfg are taken in every cycle and must only be sent
// while the block is idle; cfg.index selects row period, music level,
// channel gains or channel decays.
// One request is worked on at a time. A stop silences each channel in turn.
// A tick runs a decay pass over the channels and, while playing, steps the
// row position and plays each due row channel by channel; a note takes a
// score read, then the two registered multiplies of the sample rate.
// One command word is held back until the next one or the end of the
// request is known, so the last flag is exact. When res stalls, the
// sequencer waits and nothing is lost.
// After reset the score memory is cleared to hold entries, all ROWS * CHANNELS
// of them (256 by default), one by one; req.ready stays low meanwhile.
module tracker_sequencer_envelope #(
    parameter int ROWS     = 64,
    parameter int CHANNELS = 4
) (
    input logic       clk,
    input logic       rst_n,
    tse_req_if.sink   req,
    tse_res_if.source res,
    tse_cfg_if.sink   cfg
);

    tse_pkg::ctrl_cmd_t  cmd;
    tse_pkg::dp_status_t status;
    tse_pkg::res_t       res_data;

    // Registers are plain flip-flops, so a configuration word is always taken.
    assign cfg.ready = 1'b1;

    tse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tse_dpath #(
        .ROWS     (ROWS),
        .CHANNELS (CHANNELS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req.req_type),
        .frames        (req.frames),
        .cell_row      (req.cell_row),
        .cell_channel  (req.cell_channel),
        .cell_kind     (req.cell_kind),
        .cell_semitone (req.cell_semitone),
        .cell_octave   (req.cell_octave),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .res_ready     (res.ready),
        .res_valid     (res.valid),
        .res_data      (res_data),
        .res_last      (res.last)
    );

    // The command word fields go straight out of the output register.
    assign res.channel     = res_data.channel;
    assign res.action      = res_data.action;
    assign res.sample_rate = res_data.rate;
    assign res.level       = res_data.level;

endmodule

// ===== hw/rtl/tse_ram.sv =====
module tse_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/tse_ctrl.sv =====
module tse_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  tse_pkg::dp_status_t    status,
    output tse_pkg::ctrl_cmd_t     cmd
);

    tse_pkg::state_t state_reg;
    tse_pkg::state_t state_next;

    // Where to go once the current channel of a row is done.
    tse_pkg::state_t row_step_state;
    assign row_step_state = status.ch_last ? tse_pkg::ST_ROW_CHECK : tse_pkg::ST_ROW_READ;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tse_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tse_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = tse_pkg::ST_IDLE;
                end
            end
            tse_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = tse_pkg::ST_DISPATCH;
                end
            end
            tse_pkg::ST_DISPATCH:
            begin
                case (status.req_type)
                    tse_pkg::REQ_TICK: state_next = tse_pkg::ST_DECAY;
                    tse_pkg::REQ_STOP: state_next = tse_pkg::ST_STOP;
                    default:           state_next = tse_pkg::ST_IDLE;
                endcase
            end
            tse_pkg::ST_DECAY:
            begin
                if ((status.level_zero || status.emit_ok) && status.ch_last)
                begin
                    state_next = tse_pkg::ST_ADVANCE;
                end
            end
            tse_pkg::ST_ADVANCE:
            begin
                state_next = status.playing ? tse_pkg::ST_ROW_CHECK : tse_pkg::ST_FLUSH;
            end
            tse_pkg::ST_ROW_CHECK:
            begin
                state_next = status.row_due ? tse_pkg::ST_ROW_READ : tse_pkg::ST_FLUSH;
            end
            tse_pkg::ST_ROW_READ:
            begin
                state_next = tse_pkg::ST_CELL;
            end
            tse_pkg::ST_CELL:
            begin
                case (status.cell_kind)
                    tse_pkg::KIND_NOTE:
                    begin
                        state_next = tse_pkg::ST_NOTE_DIV;
                    end
                    tse_pkg::KIND_OFF:
                    begin
                        if (status.emit_ok)
                        begin
                            state_next = row_step_state;
                        end
                    end
                    default:
                    begin
                        state_next = row_step_state;
                    end
                endcase
            end
            tse_pkg::ST_NOTE_DIV:
            begin
                state_next = tse_pkg::ST_NOTE_EMIT;
            end
            tse_pkg::ST_NOTE_EMIT:
            begin
                if (status.emit_ok)
                begin
                    state_next = row_step_state;
                end
            end
            tse_pkg::ST_STOP:
            begin
                if (status.emit_ok && status.ch_last)
                begin
                    state_next = tse_pkg::ST_FLUSH;
                end
            end
            tse_pkg::ST_FLUSH:
            begin
                if (status.emit_ok)
                begin
                    state_next = tse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            tse_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            tse_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            tse_pkg::ST_DISPATCH:
            begin
                case (status.req_type)
                    tse_pkg::REQ_TICK:
                    begin
                        cmd.ch_first = 1'b1;
                    end
                    tse_pkg::REQ_PLAY:
                    begin
                        cmd.play_start = 1'b1;
                    end
                    tse_pkg::REQ_STOP:
                    begin
                        cmd.stop_playing = 1'b1;
                        cmd.ch_first     = 1'b1;
                    end
                    default:
                    begin
                        cmd.write_cell = 1'b1;
                    end
                endcase
            end
            tse_pkg::ST_DECAY:
            begin
                if (status.level_zero)
                begin
                    cmd.ch_next = !status.ch_last;
                end
                else if (status.emit_ok)
                begin
                    cmd.emit    = tse_pkg::EMIT_DECAY;
                    cmd.ch_next = !status.ch_last;
                end
            end
            tse_pkg::ST_ADVANCE:
            begin
                cmd.frac_add = status.playing;
            end
            tse_pkg::ST_ROW_CHECK:
            begin
                if (status.row_due)
                begin
                    cmd.row_take = 1'b1;
                    cmd.ch_first = 1'b1;
                end
            end
            tse_pkg::ST_ROW_READ:
            begin
                cmd.row_read = 1'b1;
            end
            tse_pkg::ST_CELL:
            begin
                case (status.cell_kind)
                    tse_pkg::KIND_NOTE:
                    begin
                        cmd.note_mul = 1'b1;
                    end
                    tse_pkg::KIND_OFF:
                    begin
                        if (status.emit_ok)
                        begin
                            cmd.emit        = tse_pkg::EMIT_SILENCE;
                            cmd.ch_next     = !status.ch_last;
                            cmd.row_advance = status.ch_last;
                        end
                    end
                    default:
                    begin
                        cmd.ch_next     = !status.ch_last;
                        cmd.row_advance = status.ch_last;
                    end
                endcase
            end
            tse_pkg::ST_NOTE_DIV:
            begin
                cmd.note_div = 1'b1;
            end
            tse_pkg::ST_NOTE_EMIT:
            begin
                if (status.emit_ok)
                begin
                    cmd.emit        = tse_pkg::EMIT_NOTE;
                    cmd.ch_next     = !status.ch_last;
                    cmd.row_advance = status.ch_last;
                end
            end
            tse_pkg::ST_STOP:
            begin
                if (status.emit_ok)
                begin
                    cmd.emit    = tse_pkg::EMIT_SILENCE;
                    cmd.ch_next = !status.ch_last;
                end
            end
            tse_pkg::ST_FLUSH:
            begin
                cmd.flush = status.emit_ok;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tse_dpath.sv =====
module tse_dpath #(
    parameter int ROWS     = 64,
    parameter int CHANNELS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tse_pkg::ctrl_cmd_t  cmd,
    output tse_pkg::dp_status_t status,
    input  logic [1:0]          req_type,
    input  logic [1:0]          frames,
    input  logic [5:0]          cell_row,
    input  logic [1:0]          cell_channel,
    input  logic [1:0]          cell_kind,
    input  logic [3:0]          cell_semitone,
    input  logic [3:0]          cell_octave,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                res_ready,
    output logic                res_valid,
    output tse_pkg::res_t       res_data,
    output logic                res_last
);

    localparam int DEPTH = ROWS * CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Latched request word.
    tse_pkg::req_t req_type_reg;
    logic [1:0]    frames_reg;
    logic [5:0]    cell_row_reg;
    logic [1:0]    cell_channel_reg;
    logic [1:0]    cell_kind_reg;
    logic [3:0]    cell_semitone_reg;
    logic [3:0]    cell_octave_reg;

    // Configuration.
    logic [15:0] row_period_reg;
    logic [7:0]  music_reg;
    logic [31:0] gains_reg;
    logic [31:0] decays_reg;

    // Song position and envelopes.
    logic [tse_pkg::LEVEL_W-1:0] level_reg [CHANNELS];
    logic [RW-1:0]               row_reg;
    logic [tse_pkg::FRAC_W-1:0]  frac_reg;
    logic [tse_pkg::FRAC_W-1:0]  frac_next;
    logic                        playing_reg;
    logic [CH_W-1:0]             ch_reg;
    logic [AW-1:0]               clr_addr_reg;

    // Rate pipeline.
    logic [31:0]                 prod_reg;
    logic [tse_pkg::QUOT_W-1:0]  quot_reg;

    // Result staging: one word held back so that the final one can be marked.
    logic [tse_pkg::CNT_W-1:0] cnt_reg;
    logic                      pend_valid_reg;
    tse_pkg::res_t             pend_reg;
    logic                      out_valid_reg;
    tse_pkg::res_t             out_reg;
    logic                      out_last_reg;

    logic [2:0] ch_wide;
    logic [1:0] ch2;
    assign ch_wide = 3'(ch_reg);
    assign ch2     = ch_wide[1:0];

    logic [tse_pkg::LEVEL_W-1:0] level_cur;
    logic [7:0]                  gain_byte;
    logic [7:0]                  decay_byte;
    assign level_cur  = level_reg[ch_reg];
    assign gain_byte  = gains_reg[{ch2, 3'b000} +: 8];
    assign decay_byte = decays_reg[{ch2, 3'b000} +: 8];

    // Envelope decay.
    logic [15:0] decay_prod;
    logic [7:0]  decay_level;
    assign decay_prod  = 16'(level_cur) * 16'(decay_byte);
    assign decay_level = (decay_prod[15:8] < tse_pkg::DECAY_FLOOR) ? 8'd0 : decay_prod[15:8];

    // Note start level, never zero while music is audible.
    logic [15:0] gain_prod;
    logic [7:0]  note_level;
    assign gain_prod  = 16'(gain_byte) * 16'(music_reg);
    assign note_level = (gain_prod[15:8] == 8'd0 && music_reg != 8'd0) ? 8'd1 : gain_prod[15:8];

    // Score read and note frequency.
    logic [tse_pkg::CELL_W-1:0] rd_word;
    logic [3:0]  semi_sat;
    logic [3:0]  oct_sat;
    logic [15:0] freq_base;
    logic [20:0] freq_shift;
    logic [31:0] loop_len;
    logic [63:0] quot_full;
    logic [tse_pkg::RATE_W-1:0] note_rate;

    assign semi_sat   = (rd_word[5:2] > tse_pkg::SEMI_MAX) ? tse_pkg::SEMI_MAX : rd_word[5:2];
    assign oct_sat    = (rd_word[9:6] > tse_pkg::OCT_MAX) ? tse_pkg::OCT_MAX : rd_word[9:6];
    assign freq_base  = tse_pkg::semitone_freq(semi_sat);
    assign freq_shift = (oct_sat > tse_pkg::OCT_REF)
                      ? (21'(freq_base) << (oct_sat - tse_pkg::OCT_REF))
                      : (21'(freq_base) >> (tse_pkg::OCT_REF - oct_sat));
    assign loop_len   = (ch_wide == 3'd3) ? tse_pkg::NOISE_WAVE_LEN : tse_pkg::TONE_LEN;
    assign quot_full  = 64'(prod_reg) * 64'(tse_pkg::DIV100_MAGIC);
    assign note_rate  = (quot_reg > tse_pkg::QUOT_W'(tse_pkg::RATE_MAX))
                      ? tse_pkg::RATE_MAX : quot_reg[tse_pkg::RATE_W-1:0];

    logic [tse_pkg::FRAC_W-1:0] period;
    assign period = ({1'b0, row_period_reg} < tse_pkg::MIN_PERIOD)
                  ? tse_pkg::MIN_PERIOD : {1'b0, row_period_reg};

    // New result word.
    tse_pkg::res_t new_res;
    always_comb
    begin
        new_res         = '0;
        new_res.channel = ch2;
        case (cmd.emit)
            tse_pkg::EMIT_DECAY:
            begin
                new_res.action = (decay_level == 8'd0) ? tse_pkg::ACT_SILENCE
                                                       : tse_pkg::ACT_UPDATE;
                new_res.level  = decay_level;
            end
            tse_pkg::EMIT_SILENCE:
            begin
                new_res.action = tse_pkg::ACT_SILENCE;
            end
            tse_pkg::EMIT_NOTE:
            begin
                new_res.action = tse_pkg::ACT_START;
                new_res.rate   = note_rate;
                new_res.level  = note_level;
            end
            default:
            begin
                new_res.action = tse_pkg::ACT_UPDATE;
            end
        endcase
    end

    logic store;
    logic push_pend;
    logic out_free;
    assign store     = (cmd.emit != tse_pkg::EMIT_NONE) && (cnt_reg < tse_pkg::MAX_RESULTS);
    assign push_pend = pend_valid_reg && (store || cmd.flush);
    assign out_free  = !out_valid_reg || res_ready;

    // Score memory.
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [tse_pkg::CELL_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic                       cell_in_range;

    assign cell_in_range = (32'(cell_row_reg) < ROWS) && (32'(cell_channel_reg) < CHANNELS);
    assign ram_we    = cmd.clear_step || (cmd.write_cell && cell_in_range);
    assign ram_waddr = cmd.clear_step ? clr_addr_reg
                     : AW'(32'(cell_row_reg) * CHANNELS + 32'(cell_channel_reg));
    assign ram_wdata = cmd.clear_step ? '0
                     : {cell_octave_reg, cell_semitone_reg, cell_kind_reg};
    assign ram_raddr = AW'(32'(row_reg) * CHANNELS + 32'(ch_reg));

    tse_ram #(
        .WIDTH (tse_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_score (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.row_read),
        .raddr (ram_raddr),
        .rdata (rd_word)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg      <= tse_pkg::req_t'(req_type);
            frames_reg        <= frames;
            cell_row_reg      <= cell_row;
            cell_channel_reg  <= cell_channel;
            cell_kind_reg     <= cell_kind;
            cell_semitone_reg <= cell_semitone;
            cell_octave_reg   <= cell_octave;
        end
        if (cmd.note_mul)
        begin
            prod_reg <= 32'(freq_shift) * loop_len;
        end
        if (cmd.note_div)
        begin
            quot_reg <= quot_full[tse_pkg::DIV100_SHIFT +: tse_pkg::QUOT_W];
        end
        if (store)
        begin
            pend_reg <= new_res;
        end
        if (push_pend)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_period_reg <= tse_pkg::ROW_PERIOD_RST;
            music_reg      <= tse_pkg::MUSIC_RST;
            gains_reg      <= tse_pkg::GAINS_RST;
            decays_reg     <= tse_pkg::DECAYS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tse_pkg::CFG_ROW_PERIOD: row_period_reg <= cfg_data[15:0];
                tse_pkg::CFG_MUSIC:      music_reg      <= cfg_data[7:0];
                tse_pkg::CFG_GAINS:      gains_reg      <= cfg_data;
                tse_pkg::CFG_DECAYS:     decays_reg     <= cfg_data;
                default:                 music_reg      <= music_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                level_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (CH_W'(c) == ch_reg)
                begin
                    case (cmd.emit)
                        tse_pkg::EMIT_DECAY:   level_reg[c] <= decay_level;
                        tse_pkg::EMIT_SILENCE: level_reg[c] <= '0;
                        tse_pkg::EMIT_NOTE:    level_reg[c] <= note_level;
                        default:               level_reg[c] <= level_reg[c];
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        frac_next = frac_reg;
        if (cmd.play_start)
        begin
            frac_next = '0;
        end
        else if (cmd.frac_add)
        begin
            frac_next = frac_reg + tse_pkg::FRAC_W'({frames_reg, 8'h00});
        end
        else if (cmd.row_take)
        begin
            frac_next = frac_reg - period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            frac_reg       <= '0;
            playing_reg    <= 1'b0;
            ch_reg         <= '0;
            clr_addr_reg   <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            frac_reg <= frac_next;
            if (cmd.play_start)
            begin
                row_reg     <= '0;
                playing_reg <= 1'b1;
            end
            else if (cmd.row_advance)
            begin
                row_reg <= (row_reg == RW'(ROWS - 1)) ? '0 : row_reg + RW'(1);
            end
            if (cmd.stop_playing)
            begin
                playing_reg <= 1'b0;
            end
            if (cmd.ch_first)
            begin
                ch_reg <= '0;
            end
            else if (cmd.ch_next)
            begin
                ch_reg <= ch_reg + CH_W'(1);
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (store)
            begin
                cnt_reg <= cnt_reg + tse_pkg::CNT_W'(1);
            end
            if (store)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push_pend)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_last = (clr_addr_reg == AW'(DEPTH - 1));
    assign status.req_type   = req_type_reg;
    assign status.playing    = playing_reg;
    assign status.level_zero = (level_cur == '0);
    assign status.ch_last    = (ch_reg == CH_W'(CHANNELS - 1));
    assign status.row_due    = (frac_reg >= period);
    assign status.cell_kind  = rd_word[1:0];
    assign status.emit_ok    = !pend_valid_reg || out_free;

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;
    assign res_last  = out_last_reg;

endmodule

// ===== tb/tse_command_checker.sv =====
`timescale 1ns / 1ps

module tse_command_checker
    import tse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tse_req_if   req,
    tse_res_if   res,
    tse_cfg_if   cfg,
    output int   fail_count,
    output int   pending_words,
    output int   words_checked
);

    localparam int NUM_CH   = 4;
    localparam int NUM_ROWS = 64;
    localparam int NOISE_CH = 3;

    typedef struct packed {
        logic [1:0]         channel;
        action_t            action;
        logic [RATE_W-1:0]  rate;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } command_t;

    // Commands still owed by the block, oldest first.
    command_t awaited[$];
    // Commands produced by the request word now being modeled.
    command_t step_words[$];

    logic [CELL_W-1:0]  score_mem [NUM_ROWS*NUM_CH];
    logic [LEVEL_W-1:0] ch_level [NUM_CH];
    logic [5:0]         row_ptr;
    logic [FRAC_W-1:0]  frac_acc;
    logic               playing;

    logic [15:0] period_reg;
    logic [7:0]  music_reg;
    logic [31:0] gains_reg;
    logic [31:0] decays_reg;

    initial begin
        fail_count    = 0;
        words_checked = 0;
    end

    function automatic logic [31:0] octave4_centihertz(logic [3:0] semi);
        case (semi)
            4'd0:    return 32'd26163;
            4'd1:    return 32'd27718;
            4'd2:    return 32'd29366;
            4'd3:    return 32'd31113;
            4'd4:    return 32'd32963;
            4'd5:    return 32'd34923;
            4'd6:    return 32'd36999;
            4'd7:    return 32'd39200;
            4'd8:    return 32'd41530;
            4'd9:    return 32'd44000;
            4'd10:   return 32'd46616;
            default: return 32'd49388;
        endcase
    endfunction

    // Playback rate of one period of the looped wave, saturated to the field.
    function automatic logic [RATE_W-1:0] note_rate(int ch, logic [3:0] semi, logic [3:0] oct);
        logic [31:0] freq;
        logic [63:0] quot;
        if (semi > SEMI_MAX) semi = SEMI_MAX;
        if (oct > OCT_MAX) oct = OCT_MAX;
        freq = octave4_centihertz(semi);
        if (oct > OCT_REF) freq = freq << (oct - OCT_REF);
        else freq = freq >> (OCT_REF - oct);
        quot = (64'(freq) * ((ch == NOISE_CH) ? NOISE_WAVE_LEN : TONE_LEN)) / 64'd100;
        if (quot > RATE_MAX) return RATE_MAX;
        return quot[RATE_W-1:0];
    endfunction

    // Only the first sixteen commands of one request word are reported.
    function automatic void queue_word(logic [1:0] ch, action_t act,
                                       logic [RATE_W-1:0] rate, logic [LEVEL_W-1:0] lvl);
        command_t w;
        w.channel = ch;
        w.action  = act;
        w.rate    = rate;
        w.level   = lvl;
        w.last    = 1'b0;
        if (step_words.size() < int'(MAX_RESULTS)) step_words.push_back(w);
    endfunction

    function automatic void play_row();
        logic [CELL_W-1:0]  entry;
        logic [15:0]        scaled;
        logic [LEVEL_W-1:0] lvl;
        for (int c = 0; c < NUM_CH; c++) begin
            entry = score_mem[int'(row_ptr) * NUM_CH + c];
            if (entry[1:0] == KIND_OFF) begin
                ch_level[c] = '0;
                queue_word(2'(c), ACT_SILENCE, '0, '0);
            end else if (entry[1:0] == KIND_NOTE) begin
                scaled = gains_reg[c*8 +: 8] * music_reg;
                lvl    = scaled[15:8];
                if (lvl == 0 && music_reg != 0) lvl = 8'd1;
                ch_level[c] = lvl;
                queue_word(2'(c), ACT_START, note_rate(c, entry[5:2], entry[9:6]), lvl);
            end
        end
        row_ptr = row_ptr + 6'd1;
    endfunction

    function automatic void frame_tick(logic [1:0] frames);
        logic [15:0]       decayed;
        logic [FRAC_W-1:0] per;
        for (int c = 0; c < NUM_CH; c++) begin
            if (ch_level[c] != 0) begin
                decayed     = ch_level[c] * decays_reg[c*8 +: 8];
                ch_level[c] = (decayed[15:8] < DECAY_FLOOR) ? '0 : decayed[15:8];
                if (ch_level[c] == 0) queue_word(2'(c), ACT_SILENCE, '0, '0);
                else queue_word(2'(c), ACT_UPDATE, '0, ch_level[c]);
            end
        end
        if (playing) begin
            per      = (period_reg < MIN_PERIOD) ? MIN_PERIOD : {1'b0, period_reg};
            frac_acc = frac_acc + {7'd0, frames, 8'd0};
            while (frac_acc >= per) begin
                frac_acc = frac_acc - per;
                play_row();
            end
        end
    endfunction

    function automatic void run_request(logic [1:0] kind, logic [1:0] frames,
                                        logic [5:0] row, logic [1:0] ch, logic [1:0] ckind,
                                        logic [3:0] semi, logic [3:0] oct);
        command_t w;
        step_words.delete();
        case (kind)
            REQ_TICK: frame_tick(frames);
            REQ_PLAY: begin
                row_ptr  = '0;
                frac_acc = '0;
                playing  = 1'b1;
            end
            REQ_STOP: begin
                playing = 1'b0;
                for (int c = 0; c < NUM_CH; c++) begin
                    ch_level[c] = '0;
                    queue_word(2'(c), ACT_SILENCE, '0, '0);
                end
            end
            default: score_mem[int'(row) * NUM_CH + int'(ch)] = {oct, semi, ckind};
        endcase
        if (step_words.size() > 0) begin
            w      = step_words.pop_back();
            w.last = 1'b1;
            step_words.push_back(w);
        end
        foreach (step_words[i]) awaited.push_back(step_words[i]);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_word();
        command_t want;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected word, channel %0d action %0d rate %0d level %0d last %0d",
                     $time, res.channel, res.action, res.sample_rate, res.level, res.last);
            fail_count++;
        end else begin
            want = awaited.pop_front();
            compare_field("channel", want.channel, res.channel);
            compare_field("action", want.action, res.action);
            compare_field("sample_rate", want.rate, res.sample_rate);
            compare_field("level", want.level, res.level);
            compare_field("last", want.last, res.last);
            words_checked++;
        end
    endfunction

    // Results are checked before a new request word is modeled: the block works
    // on one request at a time, so a result taken in the same cycle belongs to
    // an earlier request.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            foreach (score_mem[i]) score_mem[i] = '0;
            foreach (ch_level[i]) ch_level[i] = '0;
            row_ptr    = '0;
            frac_acc   = '0;
            playing    = 1'b0;
            period_reg = ROW_PERIOD_RST;
            music_reg  = MUSIC_RST;
            gains_reg  = GAINS_RST;
            decays_reg = DECAYS_RST;
            awaited.delete();
            pending_words <= 0;
        end else begin
            if (res.valid && res.ready) check_word();
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_ROW_PERIOD: period_reg = cfg.data[15:0];
                    CFG_MUSIC:      music_reg  = cfg.data[7:0];
                    CFG_GAINS:      gains_reg  = cfg.data;
                    CFG_DECAYS:     decays_reg = cfg.data;
                    default:        ;
                endcase
            end
            if (req.valid && req.ready)
                run_request(req.req_type, req.frames, req.cell_row, req.cell_channel,
                            req.cell_kind, req.cell_semitone, req.cell_octave);
            pending_words <= awaited.size();
        end
    end

endmodule

// ===== tb/tracker_sequencer_envelope_test.sv =====
`timescale 1ns / 1ps

module tracker_sequencer_envelope_test;
    import tse_pkg::*;

    // Generous bound: every request word at sixteen commands, each command
    // behind the longest result stall, plus the score clearing pass.
    localparam int CYCLE_LIMIT  = 400000;
    // After the last command, this many quiet cycles mean that the block is idle,
    // also after a tick that produces no command while it plays three rows.
    localparam int QUIET_CYCLES = 80;
    localparam int PHASE_WORDS  = 22;
    localparam int PHASES       = 5;

    // Score entry kinds that the package leaves unnamed. Kind 3 is spare and
    // behaves as a hold.
    localparam logic [1:0] ENTRY_HOLD  = 2'd0;
    localparam logic [1:0] ENTRY_SPARE = 2'd3;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_LONG,
        RX_SPARSE
    } rx_mode_t;

    logic clk;
    logic rst_n;

    int fail_count;
    int pending_words;
    int words_checked;
    int cycle_count;
    int words_sent;
    int ticks_sent;
    int reg_writes;
    int burst_left;
    bit req_up;

    tse_req_if req_bus();
    tse_res_if res_bus();
    tse_cfg_if cfg_bus();

    tracker_sequencer_envelope i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // The checker models the sequencer from the words it sees on all three
    // channels and reports its failure count and the commands still owed.
    tse_command_checker i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_bus),
        .res           (res_bus),
        .cfg           (cfg_bus),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .words_checked (words_checked)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog. A lost or missing command word ends up here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // The result side stalls on its own pattern. Every so often it picks a new
    // mode: always ready, a coin toss per cycle, long stalls, or rare short
    // stalls.
    initial begin
        rx_mode_t mode;
        int       mode_left;
        int       hold;
        mode      = RX_OPEN;
        mode_left = 0;
        hold      = 0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (mode_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            case (mode)
                RX_OPEN: res_bus.ready <= 1'b1;
                RX_COIN: res_bus.ready <= 1'($urandom_range(0, 1));
                RX_LONG: begin
                    if (hold > 0) begin
                        hold--;
                        res_bus.ready <= 1'b0;
                    end else if ($urandom_range(0, 5) == 0) begin
                        hold = $urandom_range(1, 20);
                        res_bus.ready <= 1'b0;
                    end else begin
                        res_bus.ready <= 1'b1;
                    end
                end
                default: res_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Valid is lowered in one place only, so that it never gets two
    // assignments in the same time step.
    task automatic lower_valid();
        if (req_up) begin
            req_bus.valid <= 1'b0;
            req_up = 1'b0;
        end
    endtask

    // The sender works in bursts of random length. Between bursts it usually
    // leaves a gap; sometimes the next burst follows directly.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 11);
            if ($urandom_range(0, 4) != 0) begin
                lower_valid();
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    // Offers one request word, waits for the edge where it was taken, then calls pace.
    task automatic send_word(req_t kind, logic [1:0] frames, logic [5:0] row,
                             logic [1:0] ch, logic [1:0] cell_kind,
                             logic [3:0] semi, logic [3:0] oct);
        req_bus.valid         <= 1'b1;
        req_bus.req_type      <= kind;
        req_bus.frames        <= frames;
        req_bus.cell_row      <= row;
        req_bus.cell_channel  <= ch;
        req_bus.cell_kind     <= cell_kind;
        req_bus.cell_semitone <= semi;
        req_bus.cell_octave   <= oct;
        req_up = 1'b1;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        words_sent++;
        if (kind == REQ_TICK) ticks_sent++;
        pace();
    endtask

    // Fields that the request kind does not use still get random values.
    task automatic send_random(req_t kind);
        send_word(kind, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                  2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    endtask

    // Leaves cfg valid high; the caller lowers it after its last write.
    task automatic write_reg(logic [1:0] which, logic [31:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= which;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        reg_writes++;
    endtask

    task automatic apply_setting(logic [15:0] period, logic [7:0] music,
                                 logic [31:0] gains, logic [31:0] decays);
        write_reg(CFG_ROW_PERIOD, {16'd0, period});
        write_reg(CFG_MUSIC, {24'd0, music});
        write_reg(CFG_GAINS, gains);
        write_reg(CFG_DECAYS, decays);
        cfg_bus.valid <= 1'b0;
    endtask

    // Waits until every expected command word has come and the block has had
    // time to finish any request that produces no command.
    task automatic settle();
        lower_valid();
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    initial begin
        int         r;
        int         n;
        bit         running;
        req_t       kind;
        logic [5:0] row;
        logic [1:0] cell_kind;

        rst_n = 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.req_type      <= REQ_TICK;
        req_bus.frames        <= '0;
        req_bus.cell_row      <= '0;
        req_bus.cell_channel  <= '0;
        req_bus.cell_kind     <= '0;
        req_bus.cell_semitone <= '0;
        req_bus.cell_octave   <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= CFG_ROW_PERIOD;
        cfg_bus.data          <= '0;
        words_sent = 0;
        ticks_sent = 0;
        reg_writes = 0;
        burst_left = 0;
        req_up     = 1'b0;
        running    = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // A zero row period is treated as the shortest one, so every frame
        // plays a row and the directed words stay few.
        apply_setting(16'd0, MUSIC_RST, GAINS_RST, DECAYS_RST);

        // Row 0: lowest note, highest note, out-of-range semitone and octave
        // (both saturate), and the A at 440 Hz on the noise channel.
        send_word(REQ_WRITE, 2'd0, 6'd0, 2'd0, KIND_NOTE, 4'd0, 4'd0);
        send_word(REQ_WRITE, 2'd0, 6'd0, 2'd1, KIND_NOTE, 4'd11, 4'd9);
        send_word(REQ_WRITE, 2'd3, 6'd0, 2'd2, KIND_NOTE, 4'd15, 4'd15);
        send_word(REQ_WRITE, 2'd0, 6'd0, 2'd3, KIND_NOTE, 4'd9, 4'd4);
        // Row 1: saturating note, note off, the spare kind that holds, and the
        // fastest sample rate the block can produce.
        send_word(REQ_WRITE, 2'd0, 6'd1, 2'd0, KIND_NOTE, 4'd12, 4'd12);
        send_word(REQ_WRITE, 2'd0, 6'd1, 2'd1, KIND_OFF, 4'd0, 4'd0);
        send_word(REQ_WRITE, 2'd0, 6'd1, 2'd2, ENTRY_SPARE, 4'd3, 4'd3);
        send_word(REQ_WRITE, 2'd0, 6'd1, 2'd3, KIND_NOTE, 4'd11, 4'd9);
        // Row 2: mixed, with low octaves that shift the frequency down.
        send_word(REQ_WRITE, 2'd0, 6'd2, 2'd0, KIND_OFF, 4'd0, 4'd0);
        send_word(REQ_WRITE, 2'd0, 6'd2, 2'd1, KIND_NOTE, 4'd5, 4'd3);
        send_word(REQ_WRITE, 2'd0, 6'd2, 2'd2, KIND_NOTE, 4'd7, 4'd1);
        send_word(REQ_WRITE, 2'd0, 6'd2, 2'd3, ENTRY_HOLD, 4'd0, 4'd0);
        send_word(REQ_WRITE, 2'd0, 6'd63, 2'd2, KIND_NOTE, 4'd3, 4'd6);

        // Three frames play rows 0 to 2 in one tick; the next ticks decay the
        // sounding channels, then stop silences all four.
        send_word(REQ_PLAY, 2'd0, 6'd0, 2'd0, ENTRY_HOLD, 4'd0, 4'd0);
        send_word(REQ_TICK, 2'd3, 6'd0, 2'd0, ENTRY_HOLD, 4'd0, 4'd0);
        send_word(REQ_TICK, 2'd3, 6'd0, 2'd0, ENTRY_HOLD, 4'd0, 4'd0);
        send_word(REQ_TICK, 2'd0, 6'd0, 2'd0, ENTRY_HOLD, 4'd0, 4'd0);
        send_word(REQ_STOP, 2'd0, 6'd0, 2'd0, ENTRY_HOLD, 4'd0, 4'd0);
        // A tick while stopped with nothing sounding produces no word.
        send_word(REQ_TICK, 2'd2, 6'd0, 2'd0, ENTRY_HOLD, 4'd0, 4'd0);
        send_word(REQ_PLAY, 2'd0, 6'd0, 2'd0, ENTRY_HOLD, 4'd0, 4'd0);
        send_word(REQ_TICK, 2'd3, 6'd0, 2'd0, ENTRY_HOLD, 4'd0, 4'd0);
        send_word(REQ_TICK, 2'd1, 6'd0, 2'd0, ENTRY_HOLD, 4'd0, 4'd0);
        settle();

        // Random phases, each under its own register setting. Each phase
        // starts the song and then mostly ticks and writes notes, biased
        // toward the first rows so that play restarts reach them again.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: apply_setting(16'd256, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                1: apply_setting(16'($urandom_range(256, 600)), 8'd0, 32'd0, 32'd0);
                2: apply_setting(16'hFFFF, 8'($urandom), $urandom, $urandom);
                3: apply_setting(16'($urandom_range(0, 255)), 8'd1, $urandom,
                                 32'h8080_8080);
                default: apply_setting(16'($urandom_range(256, 1024)), 8'($urandom),
                                       $urandom, $urandom);
            endcase
            send_random(REQ_PLAY);
            running = 1'b1;
            n = 1;
            while (n < PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    // Hold off until the block has delivered everything.
                    settle();
                end else begin
                    if (!running && r < 50) kind = REQ_PLAY;
                    else if (r < 50) kind = REQ_TICK;
                    else if (r < 82) kind = REQ_WRITE;
                    else if (r < 92) kind = REQ_TICK;
                    else if (r < 96) kind = REQ_PLAY;
                    else kind = REQ_STOP;
                    if (kind == REQ_WRITE) begin
                        row = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7))
                                                         : 6'($urandom_range(0, 63));
                        r = $urandom_range(0, 19);
                        cell_kind = (r < 12) ? KIND_NOTE :
                                    (r < 15) ? KIND_OFF :
                                    (r < 18) ? ENTRY_HOLD : ENTRY_SPARE;
                        send_word(REQ_WRITE, 2'($urandom_range(0, 3)), row,
                                  2'($urandom_range(0, 3)), cell_kind,
                                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                    end else begin
                        send_random(kind);
                    end
                    if (kind == REQ_PLAY) running = 1'b1;
                    if (kind == REQ_STOP) running = 1'b0;
                    n++;
                end
            end
            settle();
        end

        $display("Covered %0d requests (%0d ticks), %0d register writes, %0d settings.",
                 words_sent, ticks_sent, reg_writes, PHASES + 1);
        $display("Checked %0d command words, %0d failures.", words_checked, fail_count);
        if (fail_count == 0 && pending_words == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
